FILE: rtl/core/cle_pkg.sv
// ============================================================================
// cle_pkg - console line editor shared definitions
// Character codes, register indexes, channel payload types and the result
// bundle that passes from the decoder to the output stage.
// ============================================================================
`default_nettype none

package cle_pkg;

   // default line capacity
   localparam int LINE_MAX_DEFAULT = 256;

   // character codes
   localparam logic [7:0] CODE_TAB    = 8'd9;
   localparam logic [7:0] CODE_NL     = 8'd10;
   localparam logic [7:0] CODE_CR     = 8'd13;
   localparam logic [7:0] CODE_SPACE  = 8'd32;
   localparam logic [7:0] CODE_CTRL   = 8'd64;   // offset for caret notation
   localparam logic [7:0] CODE_CARET  = 8'd94;
   localparam logic [7:0] CODE_DEL    = 8'd127;

   // register indexes
   localparam logic REG_ECHO_ON    = 1'b0;
   localparam logic REG_MAX_LENGTH = 1'b1;

   localparam logic [8:0] MAX_LENGTH_RESET = 9'd256;

   typedef struct packed {
      logic [7:0] char_in;
   } req_payload_type;

   typedef struct packed {
      logic       echo_valid;
      logic [6:0] echo_char;
      logic       store_valid;
      logic [7:0] store_index;
      logic [6:0] store_char;
      logic       line_done;
      logic [8:0] line_length;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic       index;
      logic [8:0] data;
   } csr_payload_type;

   // everything one character produces; n_results of zero means nothing
   typedef struct packed {
      logic [1:0]      n_results;
      logic            echo_valid;
      logic [2:0][6:0] echo_char;
      logic            store_valid;
      logic [7:0]      store_index;
      logic [6:0]      store_char;
      logic            line_done;
      logic [8:0]      line_length;
   } bundle_type;

   // bits for a stored-character count that stays below line_max
   function automatic int count_width(input int line_max);
      count_width = (line_max > 1) ? $clog2(line_max) : 1;
   endfunction

   // bits for compares against the length limit (at least the register width)
   function automatic int limit_width(input int line_max);
      limit_width = ($clog2(line_max + 1) > 9) ? $clog2(line_max + 1) : 9;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cle_chan_if.sv
// ============================================================================
// cle_chan_if - valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ============================================================================
`default_nettype none

interface cle_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cle_decode.sv
// ============================================================================
// cle_decode - character decoder
// Turns one received character and the current count into the result bundle
// and the next count.
// ============================================================================
`default_nettype none

module cle_decode
   import cle_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
   input  wire logic [7:0]                     char_in,
   input  wire logic [count_width(LINE_MAX)-1:0] char_count,
   input  wire logic                           echo_on,
   input  wire logic [8:0]                     max_length,
   output bundle_type                          bundle,
   output logic [count_width(LINE_MAX)-1:0]    count_in
);

   localparam int CW = count_width(LINE_MAX);
   localparam int LW = limit_width(LINE_MAX);
   localparam logic [LW-1:0] LIMIT_TOP = LW'(LINE_MAX);

   logic [LW-1:0] count_ext;
   logic [LW-1:0] count_next;
   logic [LW-1:0] max_ext;
   logic [LW-1:0] limit;
   logic          done;
   logic          printable;

   always_comb begin
      count_ext  = LW'(char_count);
      count_next = count_ext + LW'(1);
      max_ext    = LW'(max_length);
      priority if (max_ext == '0) begin
         limit = LW'(1);
      end else if (max_ext > LIMIT_TOP) begin
         limit = LIMIT_TOP;
      end else begin
         limit = max_ext;
      end
      done      = (count_next >= limit);
      printable = (char_in == CODE_TAB) || (char_in >= CODE_SPACE);
   end

   always_comb begin
      bundle   = '0;
      count_in = char_count;
      priority if (char_in == CODE_CR) begin
         bundle.n_results    = 2'd1;
         bundle.echo_valid   = echo_on;
         bundle.echo_char[0] = echo_on ? CODE_NL[6:0] : 7'd0;
         bundle.line_done    = 1'b1;
         bundle.line_length  = count_ext[8:0];
         count_in            = '0;
      end else if (char_in == CODE_DEL) begin
         // DEL on an empty line does nothing
         if (char_count != '0) begin
            bundle.n_results    = 2'd1;
            bundle.echo_valid   = echo_on;
            bundle.echo_char[0] = echo_on ? CODE_DEL[6:0] : 7'd0;
            count_in            = char_count - CW'(1);
         end
      end else if (char_in < CODE_DEL) begin
         bundle.store_valid = 1'b1;
         bundle.store_index = count_ext[7:0];
         bundle.store_char  = char_in[6:0];
         bundle.line_done   = done;
         bundle.line_length = done ? count_next[8:0] : 9'd0;
         count_in           = done ? '0 : count_next[CW-1:0];
         if (!echo_on) begin
            bundle.n_results = 2'd1;
         end else if (printable) begin
            bundle.echo_valid   = 1'b1;
            bundle.echo_char[0] = char_in[6:0];
            bundle.echo_char[1] = done ? CODE_NL[6:0] : 7'd0;
            bundle.n_results    = done ? 2'd2 : 2'd1;
         end else begin
            bundle.echo_valid   = 1'b1;
            bundle.echo_char[0] = CODE_CARET[6:0];
            bundle.echo_char[1] = 7'(char_in + CODE_CTRL);
            bundle.echo_char[2] = done ? CODE_NL[6:0] : 7'd0;
            bundle.n_results    = done ? 2'd3 : 2'd2;
         end
      end else begin
         // codes above DEL are dropped
         bundle = '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/console_line_editor_echo.sv
// ============================================================================
// console_line_editor_echo - console line editor with echo
// Edits an input line one received character at a time and reports echo,
// store and line-end events on the result channel.
// ============================================================================
// Each accepted character goes through an input register, is decoded against
// the current stored-character count, and lands in a result register as a
// bundle of one to three results (echo chars, store, line end); the count is
// updated in that same cycle, so the next character can be decoded right
// behind it. The first result is offered once the character has passed the
// input register and been decoded into the result register. A character that
// yields several results holds the result register until its last result
// transfers, so throughput is one character per cycle for single-result
// characters while the receiver keeps ready high (three results at most:
// caret echo plus newline). DEL on an empty line and codes above 127 produce
// nothing and do not occupy the result register. Configuration writes are
// always ready and must only be issued while the block is idle.
// ============================================================================
`default_nettype none

module console_line_editor_echo
   import cle_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   cle_chan_if.sink   req_chan,
   cle_chan_if.source rsp_chan,
   cle_chan_if.sink   csr_chan
);

   localparam int CW = count_width(LINE_MAX);

   // configuration
   logic       echo_on_ff;
   logic [8:0] max_length_ff;
   logic       csr_xfer;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;

   // line state
   logic [CW-1:0] char_count_ff;
   logic [CW-1:0] char_count_in;

   // result register
   bundle_type bnd_in;
   bundle_type bnd_ff;
   logic       bnd_valid_ff;
   logic [1:0] pos_ff;

   logic req_xfer;
   logic rsp_xfer;
   logic final_res;
   logic drain;
   logic advance;

   // ---------------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------------
   assign final_res = (pos_ff == (bnd_ff.n_results - 2'd1));
   assign rsp_xfer  = rsp_chan.valid && rsp_chan.ready;
   // result register frees up when its last result transfers
   assign drain     = rsp_xfer && final_res;
   assign advance   = in_valid_ff && (!bnd_valid_ff || drain);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer  = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;
   assign csr_xfer = csr_chan.valid;

   // ---------------------------------------------------------------------
   // Decoder
   // ---------------------------------------------------------------------
   cle_decode #(
      .LINE_MAX (LINE_MAX)
   ) u_decode (
      .char_in    (in_char_ff),
      .char_count (char_count_ff),
      .echo_on    (echo_on_ff),
      .max_length (max_length_ff),
      .bundle     (bnd_in),
      .count_in   (char_count_in)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_on_ff    <= 1'b1;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_xfer) begin
         unique case (csr_chan.payload.index)
            REG_ECHO_ON:    echo_on_ff    <= csr_chan.payload.data[0];
            REG_MAX_LENGTH: max_length_ff <= csr_chan.payload.data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff <= req_chan.payload.char_in;
      end
   end

   // count moves as soon as a character is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
      end else if (advance) begin
         char_count_ff <= char_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else if (advance) begin
         bnd_valid_ff <= (bnd_in.n_results != 2'd0);
         pos_ff       <= 2'd0;
      end else if (drain) begin
         bnd_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else if (rsp_xfer) begin
         pos_ff <= pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bnd_ff <= bnd_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result selection: store fields ride on the first result, line end on
   // the final one; echo char stepped by position
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_chan.valid               = bnd_valid_ff;
      rsp_chan.payload.echo_valid  = bnd_ff.echo_valid;
      rsp_chan.payload.echo_char   = bnd_ff.echo_char[pos_ff];
      rsp_chan.payload.store_valid = (pos_ff == 2'd0) && bnd_ff.store_valid;
      rsp_chan.payload.store_index = (pos_ff == 2'd0) ? bnd_ff.store_index : 8'd0;
      rsp_chan.payload.store_char  = (pos_ff == 2'd0) ? bnd_ff.store_char : 7'd0;
      rsp_chan.payload.line_done   = final_res && bnd_ff.line_done;
      rsp_chan.payload.line_length = final_res ? bnd_ff.line_length : 9'd0;
      rsp_chan.payload.last        = final_res;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> (bnd_ff.n_results != 2'd0))
      else $error("result register holds an empty bundle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> (pos_ff < bnd_ff.n_results))
      else $error("result position past bundle end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(char_count_ff) < (CW + 1)'(LINE_MAX))
      else $error("stored count reached line capacity");

   a_bundle_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !final_res) |=> (rsp_chan.valid && $stable(bnd_ff)))
      else $error("bundle changed before its last result transferred");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ============================================================================
// testbench - console line editor with echo
// Feeds received characters through the request channel, predicts every
// echo/store/line-end result in step with each accepted transfer, and checks
// the result channel in order. Register writes change echo and line length
// between phases, with random idling on both channels.
// ============================================================================
`default_nettype none

module testbench;
   import cle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT   = 10;
   localparam int DRAIN_CYCLES   = 8;     // ignored chars may still be in flight
   localparam int LONG_STALL     = 150;   // receiver hold-off to back up the block
   localparam int QUIET_LIMIT    = 1000;  // cycles without any transfer
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_CHARS    = 10;
   localparam int STALL_PHASE    = 2;

   logic clock = 1'b0;
   logic reset;

   cle_chan_if #(.payload_type(req_payload_type)) req_if ();
   cle_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   cle_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   console_line_editor_echo dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Shared state
   // -------------------------------------------------------------------------
   logic [7:0]      typed_chars [$];   // characters still to be offered
   rsp_payload_type due_events [$];    // predicted results, oldest first

   // predictor copy of the registers and the line count
   logic       echo_flag;
   logic [8:0] length_reg;
   int         line_count;

   // idling controls, changed by the sequencer only on falling edges
   bit req_idle;
   bit rsp_idle;
   int stall_asked;

   int fail_count;

   // -------------------------------------------------------------------------
   // Predictor: results caused by one accepted character
   // -------------------------------------------------------------------------
   function automatic void edit_line(input logic [7:0] code);
      rsp_payload_type ev;
      logic [6:0] shown [3];
      logic [7:0] caret_sum;
      int n_shown;
      int total;
      int lim;
      int idx;
      bit done;
      ev = '0;
      n_shown = 0;
      if (code == CODE_CR) begin
         // line end, possibly empty
         ev.echo_valid  = echo_flag;
         ev.echo_char   = echo_flag ? CODE_NL[6:0] : 7'd0;
         ev.line_done   = 1'b1;
         ev.line_length = line_count[8:0];
         ev.last        = 1'b1;
         due_events.push_back(ev);
         line_count = 0;
      end else if (code == CODE_DEL) begin
         // rubout on an empty line is dropped silently
         if (line_count > 0) begin
            ev.echo_valid = echo_flag;
            ev.echo_char  = echo_flag ? CODE_DEL[6:0] : 7'd0;
            ev.last       = 1'b1;
            due_events.push_back(ev);
            line_count--;
         end
      end else if (code < CODE_DEL) begin
         lim = int'(length_reg);
         if (lim == 0) lim = 1;
         if (lim > LINE_MAX_DEFAULT) lim = LINE_MAX_DEFAULT;
         idx = line_count;
         line_count++;
         done = (line_count >= lim);
         if (echo_flag) begin
            if (code == CODE_TAB || code >= CODE_SPACE) begin
               shown[0] = code[6:0];
               n_shown = 1;
            end else begin
               caret_sum = CODE_CTRL + code;
               shown[0] = CODE_CARET[6:0];
               shown[1] = caret_sum[6:0];
               n_shown = 2;
            end
            if (done) begin
               shown[n_shown] = CODE_NL[6:0];
               n_shown++;
            end
         end
         total = (n_shown > 0) ? n_shown : 1;
         for (int k = 0; k < total; k++) begin
            ev = '0;
            ev.echo_valid = (n_shown > 0);
            ev.echo_char  = (n_shown > 0) ? shown[k] : 7'd0;
            if (k == 0) begin
               ev.store_valid = 1'b1;
               ev.store_index = idx[7:0];
               ev.store_char  = code[6:0];
            end
            if (k == total - 1) begin
               ev.last = 1'b1;
               if (done) begin
                  ev.line_done   = 1'b1;
                  ev.line_length = line_count[8:0];
               end
            end
            due_events.push_back(ev);
         end
         if (done) line_count = 0;
      end
      // codes above DEL produce nothing
   endfunction

   function automatic string event_text(input rsp_payload_type e);
      return $sformatf("echo %0b/%0d store %0b/%0d/%0d done %0b/%0d last %0b",
                       e.echo_valid, e.echo_char, e.store_valid, e.store_index,
                       e.store_char, e.line_done, e.line_length, e.last);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: one char per transfer, random gap, when idling, before each following char
   // -------------------------------------------------------------------------
   int send_gap;

   always @(posedge clock) begin : req_driver
      logic offering;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            // prediction uses the char as it stood at this edge
            edit_line(req_if.payload.char_in);
            offering = 1'b0;
            send_gap = req_idle ? int'($urandom_range(0, 10)) : 0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (typed_chars.size() != 0) begin
               req_if.payload <= typed_chars.pop_front();
               offering = 1'b1;
            end
         end
         // valid written once per edge, so a back-to-back char keeps it high
         req_if.valid <= offering;
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: in-order check, random ready gaps, long hold on request
   // -------------------------------------------------------------------------
   int recv_gap;
   int recv_hold;
   int stall_served;

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type got;
      rsp_payload_type want;
      logic ready_next;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
         recv_hold = 0;
         stall_served = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (due_events.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result: %s", $realtime, event_text(got));
            end else begin
               want = due_events.pop_front();
               if (got.echo_valid !== want.echo_valid || got.echo_char !== want.echo_char ||
                   got.store_valid !== want.store_valid ||
                   got.store_index !== want.store_index ||
                   got.store_char !== want.store_char || got.line_done !== want.line_done ||
                   got.line_length !== want.line_length || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", event_text(want));
                     $display("   actual   %s", event_text(got));
                  end
               end
            end
            recv_gap = rsp_idle ? int'($urandom_range(0, 10)) : 0;
         end
         // a new hold-off request restarts the long stall counter
         if (stall_served != stall_asked) begin
            stall_served = stall_asked;
            recv_hold = LONG_STALL;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            ready_next = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_if.ready <= ready_next;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: give up after a long run of cycles without any transfer
   // -------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("console_line_editor_echo test failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer helpers
   // -------------------------------------------------------------------------

   // register write; predictor copy follows at the accepting edge
   task automatic write_reg(input logic idx, input logic [8:0] value);
      @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= {idx, value};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == REG_ECHO_ON)
         echo_flag = value[0];
      else
         length_reg = value;
   endtask

   // block idle: nothing queued, nothing offered, nothing predicted
   task automatic wait_drained();
      @(negedge clock);
      while (typed_chars.size() != 0 || req_if.valid || due_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mixed traffic: mostly printable, with control chars, rubouts,
   // line ends and high codes
   function automatic logic [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      return 8'($urandom_range(32, 126));
      else if (pick < 70) return 8'($urandom_range(0, 31));
      else if (pick < 80) return CODE_DEL;
      else if (pick < 90) return CODE_CR;
      else                return 8'($urandom_range(128, 255));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [8:0] reg_value;
      logic [7:0] c;

      reset = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      echo_flag    = 1'b1;
      length_reg   = MAX_LENGTH_RESET;
      line_count   = 0;
      req_idle     = 1'b1;
      rsp_idle     = 1'b1;
      stall_asked  = 0;
      fail_count   = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every echo form, rubout, empty-line rubout,
      // ignored high codes, empty line end
      @(negedge clock);
      typed_chars.push_back(8'd0);
      typed_chars.push_back(8'd1);
      typed_chars.push_back(CODE_TAB);
      typed_chars.push_back(CODE_NL);
      typed_chars.push_back(8'd31);
      typed_chars.push_back(CODE_SPACE);
      typed_chars.push_back(8'd126);
      typed_chars.push_back(CODE_DEL);
      typed_chars.push_back(CODE_CR);
      typed_chars.push_back(CODE_DEL);
      typed_chars.push_back(8'd128);
      typed_chars.push_back(8'd255);
      typed_chars.push_back(CODE_CR);
      wait_drained();

      // echo off, zero limit acts as one: each stored char ends a line
      write_reg(REG_ECHO_ON, 9'd0);
      write_reg(REG_MAX_LENGTH, 9'd0);
      @(negedge clock);
      typed_chars.push_back(8'd65);
      typed_chars.push_back(8'd27);
      typed_chars.push_back(CODE_CR);
      typed_chars.push_back(CODE_DEL);
      wait_drained();

      // echo on, limit one: caret echo plus newline gives three results
      write_reg(REG_ECHO_ON, 9'd1);
      write_reg(REG_MAX_LENGTH, 9'd1);
      @(negedge clock);
      typed_chars.push_back(8'd5);
      typed_chars.push_back(8'd126);
      wait_drained();

      // limit dropped under the current count: next store still lands
      // at the current index and ends the line
      write_reg(REG_MAX_LENGTH, 9'd256);
      @(negedge clock);
      typed_chars.push_back(8'd97);
      typed_chars.push_back(8'd98);
      typed_chars.push_back(8'd99);
      wait_drained();
      write_reg(REG_MAX_LENGTH, 9'd2);
      @(negedge clock);
      typed_chars.push_back(8'd2);
      wait_drained();

      // one full line at the clamped maximum, no idling on either side
      write_reg(REG_MAX_LENGTH, 9'd511);
      @(negedge clock);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      if (line_count != 0) typed_chars.push_back(CODE_CR);
      repeat (LINE_MAX_DEFAULT) begin
         c = 8'($urandom_range(0, 126));
         if (c == CODE_CR) c = CODE_TAB;
         typed_chars.push_back(c);
      end
      wait_drained();

      // random phases, mostly with short limits so lines end often
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         reg_value = (ph == 0) ? 9'd0 : 9'($urandom_range(0, 1));
         write_reg(REG_ECHO_ON, reg_value);
         if (ph == 3)      reg_value = 9'd511;
         else if (ph == 5) reg_value = 9'd0;
         else if (ph == 6) reg_value = 9'd300;
         else              reg_value = 9'($urandom_range(1, 8));
         write_reg(REG_MAX_LENGTH, reg_value);
         @(negedge clock);
         if (ph % 3 == 0) begin
            req_idle = 1'b0;
            rsp_idle = 1'b0;
         end else begin
            req_idle = 1'($urandom_range(0, 1));
            rsp_idle = 1'($urandom_range(0, 1));
         end
         repeat (PHASE_CHARS) typed_chars.push_back(random_char());
         if (ph == STALL_PHASE) begin
            // sender keeps offering while the receiver sits on ready
            req_idle = 1'b0;
            stall_asked++;
         end
         wait_drained();
      end

      if (fail_count == 0 && due_events.size() == 0)
         $display("console_line_editor_echo test passed");
      else
         $display("console_line_editor_echo test failed");
      $finish;
   end

endmodule

`default_nettype wire
